[hw/rtl/sliding_window_event_rate_alarm_macros.svh]
// Assertion helpers for the RTL file that carries checks.
`ifndef SLIDING_WINDOW_EVENT_RATE_ALARM_MACROS_SVH
`define SLIDING_WINDOW_EVENT_RATE_ALARM_MACROS_SVH

// Checked on every clock edge while out of reset.
`define SWERA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define SWERA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[hw/rtl/swera_pkg.sv]
`timescale 1ns / 1ps

package swera_pkg;

  localparam int TIME_W      = 64;
  localparam int ID_W        = 32;
  localparam int COUNT_W     = 8;
  localparam int THRESH_W    = 8;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int IN_TDATA_W  = 96;   // event_time, source_id
  localparam int OUT_TDATA_W = 104;  // alert_id, alert_time, window_count

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_THRESHOLD = 8'd1;

  localparam logic [TIME_W-1:0]   WINDOW_RESET    = 64'd1000000;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 8'd64;

  localparam logic [COUNT_W-1:0]  COUNT_MAX = 8'd255;

endpackage

[hw/rtl/sliding_window_event_rate_alarm.sv]
`timescale 1ns / 1ps

// Sliding-window event rate alarm. Each event transfer stores its timestamp in a
// RING_DEPTH-entry ring, then the block walks back through the stored stamps one
// per cycle from a single-port read of the ring memory, counting those whose age
// (event_time minus stamp, mod 2^64) is at most window_length; the walk stops at
// the first older stamp or after fill_level entries. An alert transfer carrying
// the id, time and count (saturated at 255) is issued when the count exceeds
// alarm_threshold. An event goes through the walk and then a done state, where
// any alert is issued; in_tready is low meanwhile.
// A waiting alert does not hold off the next event, only the next alert.
// in_tdata:  [63:0] event_time, [95:64] source_id.
// out_tdata: [31:0] alert_id, [95:32] alert_time, [103:96] window_count.
// cfg_index 0 writes window_length, 1 writes alarm_threshold (low byte);
// other indexes are ignored.
module sliding_window_event_rate_alarm
  import swera_pkg::*;
#(
  parameter int RING_DEPTH = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // event_time, source_id
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // alert_id, alert_time, window_count
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "sliding_window_event_rate_alarm_macros.svh"

  localparam int PW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW   = $clog2(RING_DEPTH + 1);
  localparam int SATW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [PW-1:0]       wp_r, wp_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [CW-1:0]       left_r, left_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [PW-1:0]       rd_addr_r, rd_addr_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [TIME_W-1:0]   win_r;
  logic [THRESH_W-1:0] thr_r;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [TIME_W-1:0]   ring_mem [RING_DEPTH];
  logic [TIME_W-1:0]   rd_data_r;

  logic                in_acc;
  logic                rd_en;
  logic [TIME_W-1:0]   age;
  logic                older;
  logic [SATW-1:0]     count_ext;
  logic [COUNT_W-1:0]  count_sat;
  logic                alert;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // one wide subtract and compare per cycle against the registered ring read
  assign age   = now_r - rd_data_r;
  assign older = rd_vld_r && (age > win_r);

  assign count_ext = SATW'(count_r);
  assign count_sat = (count_ext > SATW'(COUNT_MAX)) ? COUNT_MAX : count_ext[COUNT_W-1:0];
  assign alert     = (count_sat > thr_r);

  assign rd_en = (state_r == S_WALK) && !older && (left_r != '0);

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    fill_nxt       = fill_r;
    left_nxt       = left_r;
    count_nxt      = count_r;
    rd_addr_nxt    = rd_addr_r;
    rd_vld_nxt     = 1'b0;
    now_nxt        = now_r;
    id_nxt         = id_r;
    out_data_nxt   = out_data_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt     = in_tdata[TIME_W-1:0];
          id_nxt      = in_tdata[TIME_W +: ID_W];
          wp_nxt      = (wp_r == PW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
          fill_nxt    = (fill_r == CW'(RING_DEPTH)) ? fill_r : fill_r + 1'b1;
          // the new event counts itself; the rest are older entries to read
          count_nxt   = CW'(1);
          left_nxt    = fill_nxt - 1'b1;
          rd_addr_nxt = (wp_r == '0) ? PW'(RING_DEPTH - 1) : wp_r - 1'b1;
          state_nxt   = S_WALK;
        end
      end
      S_WALK: begin
        if (older) begin
          state_nxt = S_DONE;
        end else begin
          if (rd_vld_r) begin
            count_nxt = count_r + 1'b1;
          end
          if (left_r != '0) begin
            rd_vld_nxt  = 1'b1;
            left_nxt    = left_r - 1'b1;
            rd_addr_nxt = (rd_addr_r == '0) ? PW'(RING_DEPTH - 1) : rd_addr_r - 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!alert) begin
          state_nxt = S_IDLE;
        end else if (!out_tvalid_r || out_tready) begin
          out_data_nxt   = {count_sat, now_r, id_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wp_r         <= '0;
      fill_r       <= '0;
      left_r       <= '0;
      count_r      <= '0;
      rd_addr_r    <= '0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      fill_r       <= fill_nxt;
      left_r       <= left_nxt;
      count_r      <= count_nxt;
      rd_addr_r    <= rd_addr_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    now_r      <= now_nxt;
    id_r       <= id_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WINDOW_RESET;
      thr_r <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WINDOW_LENGTH) begin
        win_r <= cfg_data;
      end else if (cfg_index == CFG_ALARM_THRESHOLD) begin
        thr_r <= cfg_data[THRESH_W-1:0];
      end
    end
  end

  // ring: write on event transfer, registered read during the walk
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring_mem[wp_r] <= in_tdata[TIME_W-1:0];
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[rd_addr_r];
    end
  end

  `SWERA_ASSERT(a_fill_bound, fill_r <= CW'(RING_DEPTH), "fill level above ring depth")
  `SWERA_ASSERT(a_walk_bound, left_r < CW'(RING_DEPTH), "walk longer than ring")
  `SWERA_ASSERT(a_alert_over_thr,
    $rose(out_tvalid_r) |-> (out_data_r[OUT_TDATA_W-1 -: COUNT_W] > thr_r),
    "alert without threshold crossing")
  `SWERA_ASSERT(a_accept_walks,
    in_acc |=> (state_r == S_WALK) && (count_r == CW'(1)),
    "event transfer did not start a walk")
  `SWERA_ASSERT_ALWAYS(a_reset_quiet,
    !rst_n |=> !out_tvalid_r && (fill_r == '0),
    "state not cleared by reset")

endmodule
